// ----- rtl/core/psi_pkg.sv -----
// Shared types and constants of the profile setpoint interpolator.
package psi_pkg;

  localparam int unsigned TIME_W     = 16;
  localparam int unsigned PRESS_W    = 21;
  localparam int unsigned NUM_POINTS = 4;
  localparam int unsigned PROD_W     = PRESS_W + TIME_W;
  localparam int unsigned QUOT_W     = PRESS_W;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [PRESS_W-1:0] PRESS_RESET = PRESS_W'(900000);
  localparam logic [TIME_W-1:0]  TIME_STEP   = TIME_W'(5000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_0  = 3'd0,
    CFG_TIME_1  = 3'd1,
    CFG_TIME_2  = 3'd2,
    CFG_TIME_3  = 3'd3,
    CFG_PRESS_0 = 3'd4,
    CFG_PRESS_1 = 3'd5,
    CFG_PRESS_2 = 3'd6,
    CFG_PRESS_3 = 3'd7
  } cfg_idx_e;

  typedef logic [NUM_POINTS-1:0][TIME_W-1:0]  time_arr_t;
  typedef logic [NUM_POINTS-1:0][PRESS_W-1:0] press_arr_t;

  typedef struct packed {
    logic               interp;
    logic               dneg;
    logic [PRESS_W-1:0] base;
    logic [PRESS_W-1:0] dmag;
    logic [TIME_W-1:0]  rem;
    logic [TIME_W-1:0]  span;
  } seg_t;

  typedef struct packed {
    logic               interp;
    logic               dneg;
    logic [PRESS_W-1:0] base;
    logic [TIME_W-1:0]  span;
    logic [TIME_W-1:0]  part;
    logic [QUOT_W-1:0]  low;
    logic [QUOT_W-1:0]  quot;
  } div_t;

endpackage

// ----- rtl/core/profile_setpoint_interpolator.sv -----
// Top level of the profile setpoint interpolator: registers, pipeline, output.
// Maps an elapsed time onto a four-breakpoint pressure profile, one word per
// cycle while no output word is stalled. A word passes segment search, one
// multiply stage, 21 restoring divide stages (one quotient bit each) and the
// output register holding the final add. The whole pipeline advances together
// and halts only while a result waits under stall. Breakpoint registers are
// read by the first stage only; write them while no word is in flight.
// cfg_ready_o is always high and every index selects a time or pressure
// register.
module profile_setpoint_interpolator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [psi_pkg::TIME_W-1:0]          elapsed_ms_i,
  input  logic                                enabled_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [psi_pkg::PRESS_W-1:0]         setpoint_pa_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [psi_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [psi_pkg::PRESS_W-1:0]         cfg_data_i
);

  localparam int unsigned NSTEP = psi_pkg::QUOT_W;

  psi_pkg::time_arr_t  time_q;
  psi_pkg::press_arr_t press_q;

  logic                        adv;
  logic                        seg_valid;
  psi_pkg::seg_t               seg;
  logic [NSTEP:0]              dv;
  psi_pkg::div_t               dd [NSTEP+1];
  logic                        out_valid_q;
  logic [psi_pkg::PRESS_W-1:0] setpoint_d, setpoint_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q[0] <= '0;
      time_q[1] <= psi_pkg::TIME_STEP;
      time_q[2] <= psi_pkg::TIME_W'(2 * psi_pkg::TIME_STEP);
      time_q[3] <= psi_pkg::TIME_W'(3 * psi_pkg::TIME_STEP);
      for (int i = 0; i < psi_pkg::NUM_POINTS; i++) begin
        press_q[i] <= psi_pkg::PRESS_RESET;
      end
    end else if (cfg_valid_i) begin
      case (psi_pkg::cfg_idx_e'(cfg_index_i))
        psi_pkg::CFG_TIME_0:  time_q[0]  <= cfg_data_i[psi_pkg::TIME_W-1:0];
        psi_pkg::CFG_TIME_1:  time_q[1]  <= cfg_data_i[psi_pkg::TIME_W-1:0];
        psi_pkg::CFG_TIME_2:  time_q[2]  <= cfg_data_i[psi_pkg::TIME_W-1:0];
        psi_pkg::CFG_TIME_3:  time_q[3]  <= cfg_data_i[psi_pkg::TIME_W-1:0];
        psi_pkg::CFG_PRESS_0: press_q[0] <= cfg_data_i;
        psi_pkg::CFG_PRESS_1: press_q[1] <= cfg_data_i;
        psi_pkg::CFG_PRESS_2: press_q[2] <= cfg_data_i;
        psi_pkg::CFG_PRESS_3: press_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  psi_seg_select u_seg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (in_valid_i),
    .elapsed_ms_i (elapsed_ms_i),
    .enabled_i    (enabled_i),
    .time_i       (time_q),
    .press_i      (press_q),
    .valid_o      (seg_valid),
    .seg_o        (seg)
  );

  psi_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (seg_valid),
    .seg_i   (seg),
    .valid_o (dv[0]),
    .div_o   (dd[0])
  );

  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    psi_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv[k]),
      .div_i   (dd[k]),
      .valid_o (dv[k+1]),
      .div_o   (dd[k+1])
    );
  end

  always_comb begin
    setpoint_d = dd[NSTEP].base;
    if (dd[NSTEP].interp) begin
      setpoint_d = dd[NSTEP].dneg ? (dd[NSTEP].base + dd[NSTEP].quot)
                                  : (dd[NSTEP].base - dd[NSTEP].quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      setpoint_q <= setpoint_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign setpoint_pa_o = setpoint_q;

endmodule

// ----- rtl/core/psi_seg_select.sv -----
// Segment search and operand setup, first pipeline stage.
module psi_seg_select (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  logic [psi_pkg::TIME_W-1:0] elapsed_ms_i,
  input  logic                       enabled_i,
  input  psi_pkg::time_arr_t         time_i,
  input  psi_pkg::press_arr_t        press_i,
  output logic                       valid_o,
  output psi_pkg::seg_t              seg_o
);

  logic                        valid_q;
  psi_pkg::seg_t               seg_d, seg_q;
  logic                        hit;
  logic [1:0]                  sel;
  logic [1:0]                  sel_m1;
  logic [psi_pkg::TIME_W-1:0]  t0, t1;
  logic [psi_pkg::PRESS_W-1:0] p0, p1;

  always_comb begin
    hit = 1'b0;
    sel = 2'd1;
    for (int i = psi_pkg::NUM_POINTS - 1; i >= 1; i--) begin
      if (elapsed_ms_i >= time_i[i-1] && elapsed_ms_i < time_i[i]) begin
        hit = 1'b1;
        sel = 2'(i);
      end
    end
    sel_m1 = sel - 2'd1;
    t0 = time_i[sel_m1];
    t1 = time_i[sel];
    p0 = press_i[sel_m1];
    p1 = press_i[sel];
  end

  always_comb begin
    seg_d.interp = 1'b0;
    seg_d.dneg   = 1'b0;
    seg_d.base   = '0;
    seg_d.dmag   = '0;
    seg_d.rem    = '0;
    seg_d.span   = psi_pkg::TIME_W'(1);
    if (enabled_i) begin
      if (hit) begin
        seg_d.interp = 1'b1;
        seg_d.dneg   = (p1 < p0);
        seg_d.base   = p1;
        seg_d.dmag   = (p1 < p0) ? (p0 - p1) : (p1 - p0);
        seg_d.rem    = t1 - elapsed_ms_i;
        seg_d.span   = t1 - t0;
      end else if (elapsed_ms_i >= time_i[psi_pkg::NUM_POINTS-1]) begin
        seg_d.base   = press_i[psi_pkg::NUM_POINTS-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      seg_q <= seg_d;
    end
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;

endmodule

// ----- rtl/core/psi_mul_stage.sv -----
// Pressure difference times remaining time, second pipeline stage.
module psi_mul_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  psi_pkg::seg_t seg_i,
  output logic          valid_o,
  output psi_pkg::div_t div_o
);

  logic                       valid_q;
  logic [psi_pkg::PROD_W-1:0] prod;
  psi_pkg::div_t              div_d, div_q;

  always_comb begin
    prod = psi_pkg::PROD_W'(seg_i.dmag) * psi_pkg::PROD_W'(seg_i.rem);
    div_d.interp = seg_i.interp;
    div_d.dneg   = seg_i.dneg;
    div_d.base   = seg_i.base;
    div_d.span   = seg_i.span;
    div_d.part   = prod[psi_pkg::PROD_W-1:psi_pkg::QUOT_W];
    div_d.low    = prod[psi_pkg::QUOT_W-1:0];
    div_d.quot   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// ----- rtl/core/psi_div_step.sv -----
// One restoring division step, one quotient bit per stage.
module psi_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  psi_pkg::div_t div_i,
  output logic          valid_o,
  output psi_pkg::div_t div_o
);

  logic                       valid_q;
  logic [psi_pkg::TIME_W:0]   trial;
  logic [psi_pkg::TIME_W:0]   diff;
  logic                       ge;
  psi_pkg::div_t              div_d, div_q;

  always_comb begin
    trial = {div_i.part, div_i.low[psi_pkg::QUOT_W-1]};
    diff  = trial - {1'b0, div_i.span};
    ge    = (trial >= {1'b0, div_i.span});
    div_d      = div_i;
    div_d.part = ge ? diff[psi_pkg::TIME_W-1:0] : trial[psi_pkg::TIME_W-1:0];
    div_d.low  = {div_i.low[psi_pkg::QUOT_W-2:0], 1'b0};
    div_d.quot = {div_i.quot[psi_pkg::QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// ----- rtl/core/psi_checker.sv -----
// Port-level checks of the profile setpoint interpolator, bound to the top level.
module psi_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        cfg_ready_o,
  input logic [psi_pkg::PRESS_W-1:0] setpoint_pa_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(setpoint_pa_o))
    else $error("stalled output word changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output word");

  a_rise_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_stall_o))
    else $error("output word appeared while the pipeline was held");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> cfg_ready_o)
    else $error("register write refused while output stalled");

endmodule

bind profile_setpoint_interpolator psi_checker u_psi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .cfg_ready_o   (cfg_ready_o),
  .setpoint_pa_o (setpoint_pa_o)
);

// ----- tb/sv/profile_setpoint_interpolator_tb.sv -----
// Self-checking testbench of the profile setpoint interpolator.
module profile_setpoint_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psi_pkg::*;

  localparam int LATENCY        = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 130;
  localparam int DIR_ROWS       = 22;

  typedef logic [PRESS_W-1:0] cfg_word_t;

  typedef struct packed {
    logic [1:0]         prof;
    logic [TIME_W-1:0]  t;
    logic               en;
    logic               known;
    logic [PRESS_W-1:0] want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [TIME_W-1:0]    elapsed_ms_i;
  logic                 enabled_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [PRESS_W-1:0]   setpoint_pa_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [PRESS_W-1:0]   cfg_data_i;

  logic [TIME_W-1:0]  bp_time  [NUM_POINTS];
  logic [PRESS_W-1:0] bp_press [NUM_POINTS];
  logic [PRESS_W-1:0] setpoint_q [$];
  logic [PRESS_W-1:0] due_setpoint;
  int                 errors = 0;
  int                 idle_cycles = 0;
  bit                 no_gaps;

  cfg_word_t profiles [4][8] = '{
    '{21'd0, 21'd5000, 21'd10000, 21'd15000,
      21'd900000, 21'd900000, 21'd900000, 21'd900000},
    '{21'd1000, 21'd1000, 21'd3000, 21'd2000,
      21'd100, 21'd2097151, 21'd0, 21'd555555},
    '{21'd0, 21'd3, 21'd65535, 21'd65535,
      21'd0, 21'd7, 21'd2097151, 21'd1},
    '{21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF,
      21'd2097151, 21'd0, 21'd2097151, 21'd2097151}
  };

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{2'd0, 16'd0,     1'b1, 1'b1, 21'd900000},
    '{2'd0, 16'd65535, 1'b1, 1'b1, 21'd900000},
    '{2'd0, 16'd15000, 1'b1, 1'b1, 21'd900000},
    '{2'd0, 16'd12345, 1'b0, 1'b1, 21'd0},
    '{2'd0, 16'd7777,  1'b1, 1'b0, 21'd0},
    '{2'd1, 16'd999,   1'b1, 1'b1, 21'd0},
    '{2'd1, 16'd1000,  1'b1, 1'b0, 21'd0},
    '{2'd1, 16'd2999,  1'b1, 1'b0, 21'd0},
    '{2'd1, 16'd2000,  1'b1, 1'b0, 21'd0},
    '{2'd1, 16'd3000,  1'b1, 1'b1, 21'd555555},
    '{2'd1, 16'd65535, 1'b1, 1'b1, 21'd555555},
    '{2'd1, 16'd0,     1'b0, 1'b1, 21'd0},
    '{2'd2, 16'd0,     1'b1, 1'b0, 21'd0},
    '{2'd2, 16'd1,     1'b1, 1'b0, 21'd0},
    '{2'd2, 16'd2,     1'b1, 1'b0, 21'd0},
    '{2'd2, 16'd40000, 1'b1, 1'b0, 21'd0},
    '{2'd2, 16'd65534, 1'b1, 1'b0, 21'd0},
    '{2'd2, 16'd65535, 1'b1, 1'b1, 21'd1},
    '{2'd2, 16'd65535, 1'b0, 1'b1, 21'd0},
    '{2'd3, 16'd0,     1'b1, 1'b1, 21'd0},
    '{2'd3, 16'd65534, 1'b1, 1'b1, 21'd0},
    '{2'd3, 16'd65535, 1'b1, 1'b1, 21'd2097151}
  };

  profile_setpoint_interpolator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .elapsed_ms_i  (elapsed_ms_i),
    .enabled_i     (enabled_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .setpoint_pa_o (setpoint_pa_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic logic [PRESS_W-1:0] predict_setpoint(logic [TIME_W-1:0] t, logic en);
    longint slope, offset, span, r;
    if (!en) return '0;
    for (int i = 1; i < NUM_POINTS; i++) begin
      if (t >= bp_time[i-1] && t < bp_time[i]) begin
        slope  = longint'(bp_press[i]) - longint'(bp_press[i-1]);
        offset = longint'(t) - longint'(bp_time[i]);
        span   = longint'(bp_time[i]) - longint'(bp_time[i-1]);
        r      = longint'(bp_press[i]) + (slope * offset) / span;
        return r[PRESS_W-1:0];
      end
    end
    if (t >= bp_time[NUM_POINTS-1]) return bp_press[NUM_POINTS-1];
    return '0;
  endfunction

  task automatic load_profile(input cfg_word_t words [8]);
    cfg_idx_e idx;
    cfg_valid_i <= 1'b1;
    for (int k = 0; k < 8; k++) begin
      idx = cfg_idx_e'(k);
      cfg_index_i <= idx;
      cfg_data_i  <= words[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      if (idx < CFG_PRESS_0) bp_time[k] = words[k][TIME_W-1:0];
      else bp_press[k - NUM_POINTS] = words[k];
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic build_profile(input int mode, output cfg_word_t words [8]);
    logic [TIME_W-1:0]  tp [NUM_POINTS];
    logic [PRESS_W-1:0] pp;
    for (int i = 0; i < NUM_POINTS; i++) begin
      case (mode)
        0: begin
          tp[i] = (i == 0) ? 16'($urandom_range(0, 2000))
                           : tp[i-1] + 16'($urandom_range(1, 20000));
        end
        1: begin
          tp[i] = (i == 0) ? 16'($urandom_range(0, 100))
                           : tp[i-1] + 16'($urandom_range(0, 10));
        end
        2: begin
          tp[i] = 16'($urandom);
        end
        default: begin
          tp[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
      endcase
      if (mode == 3) pp = $urandom_range(0, 1) ? '1 : '0;
      else pp = PRESS_W'($urandom_range(0, 2097151));
      words[i] = {5'($urandom_range(0, 31)), tp[i]};
      words[i + NUM_POINTS] = pp;
    end
  endtask

  task automatic send_word(input logic [TIME_W-1:0] t, input logic en,
                           input logic known, input logic [PRESS_W-1:0] want);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    elapsed_ms_i <= t;
    enabled_i    <= en;
    do @(posedge clk_i); while (in_stall_o);
    setpoint_q.push_back(known ? want : predict_setpoint(t, en));
  endtask

  // hold the sender until every word in flight has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (setpoint_q.size() != 0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    int hold;
    out_stall_i = 1'b0;
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o || out_stall_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (setpoint_q.size() == 0) begin
        $error("setpoint_pa: unexpected word %0d", setpoint_pa_o);
        errors++;
      end else begin
        due_setpoint = setpoint_q.pop_front();
        if (setpoint_pa_o !== due_setpoint) begin
          $error("setpoint_pa: expected %0d, actual %0d", due_setpoint, setpoint_pa_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("profile_setpoint_interpolator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                cur_prof;
    int                sel;
    cfg_word_t         words [8];
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] top;
    no_gaps      = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    elapsed_ms_i = '0;
    enabled_i    = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_TIME_0;
    cfg_data_i   = '0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      bp_time[i]  = TIME_W'(i * TIME_STEP);
      bp_press[i] = PRESS_RESET;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    cur_prof = 0;
    foreach (dir_rows[r]) begin
      if (int'(dir_rows[r].prof) != cur_prof) begin
        drain();
        cur_prof = dir_rows[r].prof;
        load_profile(profiles[cur_prof]);
      end
      send_word(dir_rows[r].t, dir_rows[r].en, dir_rows[r].known, dir_rows[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      no_gaps = (ph % 3 == 2);
      build_profile(ph % 4, words);
      load_profile(words);
      top = bp_time[0];
      for (int i = 1; i < NUM_POINTS; i++) if (bp_time[i] > top) top = bp_time[i];
      top = (top > 16'd65485) ? 16'hFFFF : top + 16'd50;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) t = 16'($urandom_range(0, top));
        else if (sel < 8) t = bp_time[$urandom_range(0, 3)] + 16'($urandom_range(0, 2)) - 16'd1;
        else t = 16'($urandom);
        send_word(t, $urandom_range(0, 15) != 0, 1'b0, '0);
      end
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("profile_setpoint_interpolator verification clean");
    end else begin
      $display("profile_setpoint_interpolator verification failed");
    end
    $finish;
  end

endmodule
